@@ src/eraz_pkg.sv @@
// Shared constants, the arctangent table and the CORDIC gain function
// for the ENU to range/azimuth/zenith pipeline. No dependencies.
package eraz_pkg;

    localparam int FIELD_W      = 32;
    localparam int DP_W         = 64;
    localparam int GAIN_W       = 31;
    localparam int AZ_Z_W       = 32;
    localparam int ZN_Z_W       = 34;
    localparam int ATAN_ENTRIES = 48;

    localparam int NUM_COMP = 3;
    localparam int COMP_E   = 0;
    localparam int COMP_N   = 1;
    localparam int COMP_U   = 2;

    localparam logic [AZ_Z_W-1:0]        HALF_TURN    = 32'h8000_0000;
    localparam logic signed [ZN_Z_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [ZN_Z_W-1:0] ZEN_MAX      = 34'sd2147483648;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
    };

    // CORDIC gain in Q30, truncated: floor(sqrt(prod(1 + 4^-i))) with the
    // product kept in Q60 and truncated at every step. Elaboration only.
    function automatic logic [GAIN_W-1:0] cordic_gain_q30(input int steps);
        logic [63:0]       p;
        logic [GAIN_W-1:0] r;
        logic [GAIN_W-1:0] t;
        int                i;
        int                b;
        p = 64'd1 << 60;
        for (i = 0; i < steps; i++) begin
            if (2 * i < 64)
            begin
                p = p + (p >> (2 * i));
            end
        end
        r = '0;
        for (b = GAIN_W - 1; b >= 0; b--) begin
            t = r | (GAIN_W'(1) << b);
            if (64'(t) * 64'(t) <= p)
            begin
                r = t;
            end
        end
        return r;
    endfunction

endpackage

@@ src/enu_to_range_azimuth_zenith.sv @@
// Top level: ENU vector to range, azimuth and zenith angle, fully pipelined.
// Depends on eraz_pkg, eraz_sqrt_cell and eraz_cordic_cell.
//
//   channel   handshake         payload
//   -------   ---------------   ----------------------------------------------
//   input     start / busy      east_comp, north_comp, up_comp
//   result    done (strobe)     range_out, azimuth_out, zenith_out, error_flag
//
// One transaction is taken every cycle; busy stays low.
// The longer of the angle and range paths sets when a result appears; at the
// defaults that is the azimuth CORDIC chain followed by the zenith chain.
// The range path (one square-root cell per root bit) runs alongside it.
// Reset clears only the valid pipeline; the datapath needs no clearing.
// Each result is shown for the single cycle that done is high; the receiver
// cannot stall the pipeline.
module enu_to_range_azimuth_zenith #(
    parameter int COORD_BITS   = 32,
    parameter int CORDIC_STEPS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [eraz_pkg::FIELD_W-1:0]  east_comp,
    input  logic signed [eraz_pkg::FIELD_W-1:0]  north_comp,
    input  logic signed [eraz_pkg::FIELD_W-1:0]  up_comp,
    output logic                                 done,
    output logic [eraz_pkg::FIELD_W-1:0]         range_out,
    output logic [eraz_pkg::FIELD_W-1:0]         azimuth_out,
    output logic [eraz_pkg::FIELD_W-1:0]         zenith_out,
    output logic                                 error_flag
);

    import eraz_pkg::*;

    localparam int CB      = COORD_BITS;
    localparam int S       = CORDIC_STEPS;
    localparam int HW      = (CB + 1) / 2;
    localparam int LW      = CB - HW;
    localparam int GUARD   = 59 - CB;
    localparam int SQ_W    = 2 * CB;
    localparam int UK_W    = CB + GAIN_W;
    localparam int W_W     = UK_W + GUARD;
    localparam int RND_SH  = GAIN_W - 1;
    localparam int KMAG_W  = W_W - RND_SH;
    localparam int ATAG_W  = KMAG_W + 2;
    localparam int ZTAG_W  = AZ_Z_W + 1;
    localparam int ANG_W   = ZTAG_W + ZN_Z_W;
    localparam int A_LAT   = 2 * S + 3;
    localparam int R_LAT   = CB + 4;
    localparam int P_LAT   = (A_LAT > R_LAT) ? A_LAT : R_LAT;
    localparam int LAT     = P_LAT + 1;
    localparam int RNG_DLY = P_LAT - R_LAT;
    localparam int ANG_DLY = P_LAT - A_LAT;

    localparam logic [GAIN_W-1:0] GAIN = cordic_gain_q30(CORDIC_STEPS);

    logic acc;
    logic [LAT-1:0] vld_reg;

    // ---------------------------------------------------------------- stage 1
    logic signed [CB-1:0] comp_in [NUM_COMP];
    logic [CB-1:0]        mag_in  [NUM_COMP];

    logic [2*LW-1:0]      phh_next [NUM_COMP];
    logic [CB-1:0]        phl_next [NUM_COMP];
    logic [2*HW-1:0]      pll_next [NUM_COMP];
    logic [2*LW-1:0]      phh_reg  [NUM_COMP];
    logic [CB-1:0]        phl_reg  [NUM_COMP];
    logic [2*HW-1:0]      pll_reg  [NUM_COMP];
    logic [LW+GAIN_W-1:0] ukh_reg;
    logic [HW+GAIN_W-1:0] ukl_reg;
    logic signed [CB-1:0] e1_reg;
    logic signed [CB-1:0] n1_reg;
    logic                 uneg1_reg;
    logic                 err1_reg;

    assign busy = 1'b0;
    assign acc  = start & ~busy;

    // Each component is the low COORD_BITS bits of the sign-extended field.
    assign comp_in[COMP_E] = CB'(DP_W'(east_comp));
    assign comp_in[COMP_N] = CB'(DP_W'(north_comp));
    assign comp_in[COMP_U] = CB'(DP_W'(up_comp));

    always_comb
    begin
        for (int c = 0; c < NUM_COMP; c++) begin
            mag_in[c]   = comp_in[c][CB-1] ? $unsigned(-comp_in[c]) : $unsigned(comp_in[c]);
            phh_next[c] = (2*LW)'(mag_in[c][CB-1:HW]) * (2*LW)'(mag_in[c][CB-1:HW]);
            phl_next[c] = CB'(mag_in[c][CB-1:HW]) * CB'(mag_in[c][HW-1:0]);
            pll_next[c] = (2*HW)'(mag_in[c][HW-1:0]) * (2*HW)'(mag_in[c][HW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_COMP; c++) begin
            phh_reg[c] <= phh_next[c];
            phl_reg[c] <= phl_next[c];
            pll_reg[c] <= pll_next[c];
        end
        ukh_reg   <= (LW+GAIN_W)'(mag_in[COMP_U][CB-1:HW]) * (LW+GAIN_W)'(GAIN);
        ukl_reg   <= (HW+GAIN_W)'(mag_in[COMP_U][HW-1:0]) * (HW+GAIN_W)'(GAIN);
        e1_reg    <= comp_in[COMP_E];
        n1_reg    <= comp_in[COMP_N];
        uneg1_reg <= comp_in[COMP_U][CB-1];
        err1_reg  <= (comp_in[COMP_N] == '0);
    end

    // ---------------------------------------------------------------- stage 2
    logic [SQ_W-1:0]          sq_next [NUM_COMP];
    logic [SQ_W-1:0]          sq_reg  [NUM_COMP];
    logic signed [DP_W-1:0]   ne;
    logic signed [DP_W-1:0]   ee;
    logic signed [DP_W-1:0]   ax0_next;
    logic signed [DP_W-1:0]   ay0_next;
    logic signed [AZ_Z_W-1:0] az0_next;
    logic [UK_W-1:0]          uk;
    logic [W_W-1:0]           wsum;
    logic signed [DP_W-1:0]   ax0_reg;
    logic signed [DP_W-1:0]   ay0_reg;
    logic signed [AZ_Z_W-1:0] az0_reg;
    logic [ATAG_W-1:0]        atag0_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_COMP; c++) begin
            sq_next[c] = (SQ_W'(phh_reg[c]) << (2 * HW))
                       + (SQ_W'(phl_reg[c]) << (HW + 1))
                       + SQ_W'(pll_reg[c]);
        end
    end

    // A negative north component turns the vector by a half turn first.
    assign ne       = DP_W'(n1_reg);
    assign ee       = DP_W'(e1_reg);
    assign ax0_next = (n1_reg[CB-1] ? -ne : ne) <<< GUARD;
    assign ay0_next = (n1_reg[CB-1] ? -ee : ee) <<< GUARD;
    assign az0_next = n1_reg[CB-1] ? signed'(HALF_TURN) : '0;

    // Up magnitude times the CORDIC gain, rounded half up at the Q30 point.
    assign uk   = (UK_W'(ukh_reg) << HW) + UK_W'(ukl_reg);
    assign wsum = (W_W'(uk) << GUARD) + (W_W'(1) << (RND_SH - 1));

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_COMP; c++) begin
            sq_reg[c] <= sq_next[c];
        end
        ax0_reg   <= ax0_next;
        ay0_reg   <= ay0_next;
        az0_reg   <= az0_next;
        atag0_reg <= {err1_reg, uneg1_reg, wsum[W_W-1:RND_SH]};
    end

    // ------------------------------------------------------------ range path
    logic [SQ_W-1:0] s_reg;
    logic [SQ_W-1:0] rem_w  [CB+1];
    logic [CB-1:0]   root_w [CB+1];
    logic [CB:0]     rnd;
    logic [63:0]     rnd_wide;
    logic [FIELD_W-1:0] rng_reg;
    logic [FIELD_W-1:0] rng_d;

    always_ff @(posedge clk)
    begin
        s_reg <= sq_reg[COMP_E] + sq_reg[COMP_N] + sq_reg[COMP_U];
    end

    assign rem_w[0]  = s_reg;
    assign root_w[0] = '0;

    for (genvar k = 0; k < CB; k++) begin : g_sqrt
        eraz_sqrt_cell #(
            .COORD_BITS (CB),
            .BIT        (CB - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rem_in   (rem_w[k]),
            .root_in  (root_w[k]),
            .rem_out  (rem_w[k+1]),
            .root_out (root_w[k+1])
        );
    end

    // Round half up: s > r*(r+1) exactly when the remainder exceeds r.
    assign rnd      = (CB+1)'(root_w[CB]) + (CB+1)'(rem_w[CB] > SQ_W'(root_w[CB]));
    assign rnd_wide = 64'(rnd);

    always_ff @(posedge clk)
    begin
        rng_reg <= (rnd_wide > 64'hFFFF_FFFF) ? '1 : rnd_wide[FIELD_W-1:0];
    end

    // ------------------------------------------------------ azimuth CORDIC
    logic signed [DP_W-1:0]   ax   [S+1];
    logic signed [DP_W-1:0]   ay   [S+1];
    logic signed [AZ_Z_W-1:0] az   [S+1];
    logic [ATAG_W-1:0]        atag [S+1];

    assign ax[0]   = ax0_reg;
    assign ay[0]   = ay0_reg;
    assign az[0]   = az0_reg;
    assign atag[0] = atag0_reg;

    for (genvar k = 0; k < S; k++) begin : g_az
        eraz_cordic_cell #(
            .STEP  (k),
            .Z_W   (AZ_Z_W),
            .TAG_W (ATAG_W)
        ) u_cell (
            .clk     (clk),
            .x_in    (ax[k]),
            .y_in    (ay[k]),
            .z_in    (az[k]),
            .tag_in  (atag[k]),
            .x_out   (ax[k+1]),
            .y_out   (ay[k+1]),
            .z_out   (az[k+1]),
            .tag_out (atag[k+1])
        );
    end

    // --------------------------------------------------------- zenith setup
    logic [KMAG_W-1:0]        kmag_a;
    logic                     swap;
    logic signed [DP_W-1:0]   kup_pos;
    logic signed [DP_W-1:0]   zx0_reg;
    logic signed [DP_W-1:0]   zy0_reg;
    logic signed [ZN_Z_W-1:0] zz0_reg;
    logic [ZTAG_W-1:0]        ztag0_reg;

    assign kmag_a  = atag[S][KMAG_W-1:0];
    assign kup_pos = signed'(DP_W'(kmag_a));
    // A negative scaled up component is turned by a quarter turn first.
    assign swap    = atag[S][KMAG_W] && (kmag_a != '0);

    always_ff @(posedge clk)
    begin
        zx0_reg   <= swap ? ax[S] : kup_pos;
        zy0_reg   <= swap ? kup_pos : ax[S];
        zz0_reg   <= swap ? QUARTER_TURN : '0;
        ztag0_reg <= {atag[S][KMAG_W+1], az[S]};
    end

    // ------------------------------------------------------- zenith CORDIC
    logic signed [DP_W-1:0]   zx   [S+1];
    logic signed [DP_W-1:0]   zy   [S+1];
    logic signed [ZN_Z_W-1:0] zz   [S+1];
    logic [ZTAG_W-1:0]        ztag [S+1];

    assign zx[0]   = zx0_reg;
    assign zy[0]   = zy0_reg;
    assign zz[0]   = zz0_reg;
    assign ztag[0] = ztag0_reg;

    for (genvar k = 0; k < S; k++) begin : g_zn
        eraz_cordic_cell #(
            .STEP  (k),
            .Z_W   (ZN_Z_W),
            .TAG_W (ZTAG_W)
        ) u_cell (
            .clk     (clk),
            .x_in    (zx[k]),
            .y_in    (zy[k]),
            .z_in    (zz[k]),
            .tag_in  (ztag[k]),
            .x_out   (zx[k+1]),
            .y_out   (zy[k+1]),
            .z_out   (zz[k+1]),
            .tag_out (ztag[k+1])
        );
    end

    // ---------------------------------------------------------- alignment
    logic [ANG_W-1:0] ang_w;
    logic [ANG_W-1:0] ang_d;

    assign ang_w = {ztag[S], zz[S]};

    if (RNG_DLY > 0) begin : g_rng_dly
        logic [FIELD_W-1:0] rd_reg [RNG_DLY];
        always_ff @(posedge clk)
        begin
            rd_reg[0] <= rng_reg;
            for (int i = 1; i < RNG_DLY; i++) begin
                rd_reg[i] <= rd_reg[i-1];
            end
        end
        assign rng_d = rd_reg[RNG_DLY-1];
    end
    else begin : g_rng_now
        assign rng_d = rng_reg;
    end

    if (ANG_DLY > 0) begin : g_ang_dly
        logic [ANG_W-1:0] ad_reg [ANG_DLY];
        always_ff @(posedge clk)
        begin
            ad_reg[0] <= ang_w;
            for (int i = 1; i < ANG_DLY; i++) begin
                ad_reg[i] <= ad_reg[i-1];
            end
        end
        assign ang_d = ad_reg[ANG_DLY-1];
    end
    else begin : g_ang_now
        assign ang_d = ang_w;
    end

    // ------------------------------------------------------- output stage
    logic                     err_o;
    logic [AZ_Z_W-1:0]        az_o;
    logic signed [ZN_Z_W-1:0] zz_o;
    logic [FIELD_W-1:0]       zen_clamped;
    logic [FIELD_W-1:0]       range_reg;
    logic [FIELD_W-1:0]       azimuth_reg;
    logic [FIELD_W-1:0]       zenith_reg;
    logic                     error_reg;

    assign err_o = ang_d[ANG_W-1];
    assign az_o  = ang_d[ANG_W-2 -: AZ_Z_W];
    assign zz_o  = signed'(ang_d[ZN_Z_W-1:0]);

    always_comb
    begin
        if (zz_o < 0)
        begin
            zen_clamped = '0;
        end
        else if (zz_o > ZEN_MAX)
        begin
            zen_clamped = ZEN_MAX[FIELD_W-1:0];
        end
        else
        begin
            zen_clamped = zz_o[FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg   <= err_o ? '0 : rng_d;
        azimuth_reg <= err_o ? '0 : az_o;
        zenith_reg  <= err_o ? '0 : zen_clamped;
        error_reg   <= err_o;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], acc};
        end
    end

    assign done        = vld_reg[LAT-1];
    assign range_out   = range_reg;
    assign azimuth_out = azimuth_reg;
    assign zenith_out  = zenith_reg;
    assign error_flag  = error_reg;

    // ----------------------------------------------------------- assertions
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> ##LAT done)
        else $error("accepted transaction did not produce a result in time");

    a_north_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && comp_in[COMP_N] == '0) |-> ##LAT (done && error_flag))
        else $error("zero north component did not raise error_flag");

    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error_flag) |-> (range_out == '0 && azimuth_out == '0 && zenith_out == '0))
        else $error("error result carries nonzero fields");

    a_range_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !error_flag) |-> (range_out != '0))
        else $error("nonzero vector gave zero range");

    a_zenith_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (zenith_out <= ZEN_MAX[FIELD_W-1:0]))
        else $error("zenith angle above half turn");

endmodule

@@ src/eraz_sqrt_cell.sv @@
// One bit of the restoring square root: decides a single root bit and
// registers the partial remainder and root. Depends on nothing.
module eraz_sqrt_cell #(
    parameter int COORD_BITS = 32,
    parameter int BIT        = 0
) (
    input  logic                      clk,
    input  logic [2*COORD_BITS-1:0]   rem_in,
    input  logic [COORD_BITS-1:0]     root_in,
    output logic [2*COORD_BITS-1:0]   rem_out,
    output logic [COORD_BITS-1:0]     root_out
);

    localparam int RW = 2 * COORD_BITS;
    localparam int TW = RW + 1;

    logic [TW-1:0]         trial;
    logic [TW-1:0]         diff;
    logic                  fits;
    logic [RW-1:0]         rem_next;
    logic [RW-1:0]         rem_reg;
    logic [COORD_BITS-1:0] root_next;
    logic [COORD_BITS-1:0] root_reg;

    // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b); root bits below b are still zero.
    assign trial = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    assign diff  = TW'(rem_in) - trial;
    assign fits  = ~diff[TW-1];

    always_comb
    begin
        if (fits)
        begin
            rem_next  = diff[RW-1:0];
            root_next = root_in | (COORD_BITS'(1) << BIT);
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

@@ src/eraz_cordic_cell.sv @@
// One CORDIC vectoring micro-rotation with its output registers; carries
// a side tag along unchanged. Depends on eraz_pkg.
module eraz_cordic_cell #(
    parameter int STEP  = 0,
    parameter int Z_W   = 32,
    parameter int TAG_W = 1
) (
    input  logic                              clk,
    input  logic signed [eraz_pkg::DP_W-1:0]  x_in,
    input  logic signed [eraz_pkg::DP_W-1:0]  y_in,
    input  logic signed [Z_W-1:0]             z_in,
    input  logic [TAG_W-1:0]                  tag_in,
    output logic signed [eraz_pkg::DP_W-1:0]  x_out,
    output logic signed [eraz_pkg::DP_W-1:0]  y_out,
    output logic signed [Z_W-1:0]             z_out,
    output logic [TAG_W-1:0]                  tag_out
);

    import eraz_pkg::*;

    logic signed [DP_W-1:0] dx;
    logic signed [DP_W-1:0] dy;
    logic signed [Z_W-1:0]  ang;
    logic signed [DP_W-1:0] x_next;
    logic signed [DP_W-1:0] y_next;
    logic signed [Z_W-1:0]  z_next;
    logic signed [DP_W-1:0] x_reg;
    logic signed [DP_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [TAG_W-1:0]       tag_reg;

    assign dx  = y_in >>> STEP;
    assign dy  = x_in >>> STEP;
    assign ang = signed'(Z_W'(ATAN_TURNS[STEP]));

    always_comb
    begin
        if (y_in > 0)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ang;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        tag_reg <= tag_in;
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign tag_out = tag_reg;

endmodule

@@ test/enu_to_range_azimuth_zenith_tb.sv @@
// Self-checking testbench for enu_to_range_azimuth_zenith: directed and random
// ENU vectors, with a bit-accurate range/azimuth/zenith predictor.
// Depends on eraz_pkg and the RTL top level only.
module enu_to_range_azimuth_zenith_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import eraz_pkg::FIELD_W;

    localparam int COORD_BITS   = 32;
    localparam int CORDIC_STEPS = 32;
    localparam int GUARD        = 59 - COORD_BITS;
    localparam int NUM_RANDOM   = 1350;
    localparam int DRAIN_CYCLES = 2 * CORDIC_STEPS + COORD_BITS + 16;

    localparam longint ANG_HALF    = 64'sd2147483648;
    localparam longint ANG_QUARTER = 64'sd1073741824;

    localparam logic signed [FIELD_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [FIELD_W-1:0] S_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [FIELD_W-1:0] east;
        logic signed [FIELD_W-1:0] north;
        logic signed [FIELD_W-1:0] up;
    } enu_vec_t;

    typedef struct packed {
        logic [FIELD_W-1:0] rng;
        logic [FIELD_W-1:0] azim;
        logic [FIELD_W-1:0] zen;
        logic               err;
    } polar_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [FIELD_W-1:0] east_comp  = '0;
    logic signed [FIELD_W-1:0] north_comp = '0;
    logic signed [FIELD_W-1:0] up_comp    = '0;
    logic               done;
    logic [FIELD_W-1:0] range_out;
    logic [FIELD_W-1:0] azimuth_out;
    logic [FIELD_W-1:0] zenith_out;
    logic               error_flag;

    enu_vec_t vec_pending[$];
    polar_t   polar_expected[$];
    int       err_count  = 0;
    int       burst_left = 8;
    int       gap_left   = 0;

    longint unsigned k_gain;
    longint          atan_tbl [32] = '{
        64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
        64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
        64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
        64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D,
        64'h0000_28BE, 64'h0000_145F, 64'h0000_0A30, 64'h0000_0518,
        64'h0000_028C, 64'h0000_0146, 64'h0000_00A3, 64'h0000_0051,
        64'h0000_0029, 64'h0000_0014, 64'h0000_000A, 64'h0000_0005,
        64'h0000_0003, 64'h0000_0001, 64'h0000_0001, 64'h0000_0000
    };

    enu_to_range_azimuth_zenith #(
        .COORD_BITS   (COORD_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .east_comp   (east_comp),
        .north_comp  (north_comp),
        .up_comp     (up_comp),
        .done        (done),
        .range_out   (range_out),
        .azimuth_out (azimuth_out),
        .zenith_out  (zenith_out),
        .error_flag  (error_flag)
    );

    function automatic longint unsigned isqrt(input logic [127:0] s);
        longint unsigned root;
        longint unsigned trial;
        int              b;
        root = 0;
        for (b = 48; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (128'(trial) * 128'(trial) <= s)
            begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic longint unsigned calc_gain();
        longint unsigned p;
        int              i;
        p = 64'd1 << 60;
        for (i = 0; i < CORDIC_STEPS; i++) begin
            if (2 * i < 64)
            begin
                p = p + (p >> (2 * i));
            end
        end
        return isqrt(128'(p));
    endfunction

    // Vectoring mode: drives y toward zero and accumulates the rotation angle.
    function automatic longint cordic_vec(input longint x_in, input longint y_in,
                                          input longint z_in, output longint z_out);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        int     i;
        x = x_in;
        y = y_in;
        z = z_in;
        for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_tbl[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_tbl[i];
            end
        end
        z_out = z;
        return x;
    endfunction

    function automatic polar_t enu_to_polar(input enu_vec_t v);
        polar_t          res;
        longint          e;
        longint          n;
        longint          u;
        longint unsigned me;
        longint unsigned mn;
        longint unsigned mu;
        longint unsigned root;
        logic [127:0]    sq;
        logic [127:0]    kw;
        longint          x;
        longint          y;
        longint          z;
        longint          x2;
        longint          y2;
        longint          z2;
        longint          kup;
        longint          tmp;
        e = longint'(v.east);
        n = longint'(v.north);
        u = longint'(v.up);
        res = '{rng: '0, azim: '0, zen: '0, err: 1'b1};
        if (n == 0)
        begin
            return res;
        end
        me = (e < 0) ? -e : e;
        mn = (n < 0) ? -n : n;
        mu = (u < 0) ? -u : u;

        // Range: floor root, then round half up.
        sq = 128'(me) * 128'(me) + 128'(mn) * 128'(mn) + 128'(mu) * 128'(mu);
        root = isqrt(sq);
        if (sq > 128'(root) * 128'(root + 1))
        begin
            root = root + 1;
        end
        if (root > 64'hFFFF_FFFF)
        begin
            root = 64'hFFFF_FFFF;
        end

        // Azimuth, with a half-turn pre-rotation for a southward vector.
        x = n <<< GUARD;
        y = e <<< GUARD;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = ANG_HALF;
        end
        x = cordic_vec(x, y, z, z);

        // Up gets the CORDIC gain so it matches the horizontal magnitude.
        kw  = 128'(mu << GUARD) * 128'(k_gain) + (128'd1 << 29);
        kup = longint'(kw[93:30]);
        if (u < 0)
        begin
            kup = -kup;
        end

        x2 = kup;
        y2 = x;
        z2 = 0;
        if (x2 < 0)
        begin
            tmp = x2;
            x2  = y2;
            y2  = -tmp;
            z2  = ANG_QUARTER;
        end
        tmp = cordic_vec(x2, y2, z2, z2);
        if (z2 < 0)
        begin
            z2 = 0;
        end
        if (z2 > ANG_HALF)
        begin
            z2 = ANG_HALF;
        end

        res.rng  = root[FIELD_W-1:0];
        res.azim = z[FIELD_W-1:0];
        res.zen  = z2[FIELD_W-1:0];
        res.err  = 1'b0;
        return res;
    endfunction

    function automatic logic signed [FIELD_W-1:0] rand_comp();
        logic signed [FIELD_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v = S_MAX;
            1: v = S_MIN;
            2: v = '0;
            3: v = 1;
            4: v = -1;
            5, 6: v = v >>> $urandom_range(11, 31);
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            east_comp  <= '0;
            north_comp <= '0;
            up_comp    <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                polar_expected.push_back(enu_to_polar(vec_pending.pop_front()));
            end
            if (start && busy)
            begin
                // The current transaction has not been taken yet; keep it on the bus.
            end
            else if (gap_left != 0)
            begin
                start    <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (vec_pending.size() != 0)
            begin
                start      <= 1'b1;
                east_comp  <= vec_pending[0].east;
                north_comp <= vec_pending[0].north;
                up_comp    <= vec_pending[0].up;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        polar_t got;
        polar_t want;
        if (rst_n && done)
        begin
            got = '{rng: range_out, azim: azimuth_out, zen: zenith_out, err: error_flag};
            if (polar_expected.size() == 0)
            begin
                $display("%0t: unexpected result range=%h az=%h zen=%h err=%b",
                         $time, got.rng, got.azim, got.zen, got.err);
                err_count = err_count + 1;
            end
            else
            begin
                want = polar_expected.pop_front();
                if (got != want)
                begin
                    $display("%0t: mismatch expected range=%h az=%h zen=%h err=%b, got range=%h az=%h zen=%h err=%b",
                             $time, want.rng, want.azim, want.zen, want.err,
                             got.rng, got.azim, got.zen, got.err);
                    err_count = err_count + 1;
                end
            end
        end
    end

    initial begin
        enu_vec_t v;
        int       k;
        k_gain = calc_gain();

        // Directed: zero vector, north zero, axis and extreme vectors, both
        // half-turn and quarter-turn pre-rotations, zenith near its limits,
        // and range rounding around the half.
        vec_pending.push_back('{32'sd0, 32'sd0, 32'sd0});
        vec_pending.push_back('{32'sd5, 32'sd0, -32'sd7});
        vec_pending.push_back('{S_MIN, 32'sd0, S_MAX});
        vec_pending.push_back('{32'sd0, 32'sd1, 32'sd0});
        vec_pending.push_back('{32'sd0, -32'sd1, 32'sd0});
        vec_pending.push_back('{32'sd1, 32'sd1, 32'sd1});
        vec_pending.push_back('{32'sd1, 32'sd1, 32'sd0});
        vec_pending.push_back('{32'sd1, 32'sd1, -32'sd1});
        vec_pending.push_back('{S_MAX, S_MAX, S_MAX});
        vec_pending.push_back('{S_MIN, S_MIN, S_MIN});
        vec_pending.push_back('{S_MAX, S_MIN, S_MAX});
        vec_pending.push_back('{S_MIN, S_MAX, S_MIN});
        vec_pending.push_back('{32'sd0, S_MIN, 32'sd0});
        vec_pending.push_back('{32'sd0, S_MAX, 32'sd0});
        vec_pending.push_back('{S_MIN, 32'sd1, 32'sd0});
        vec_pending.push_back('{S_MAX, -32'sd1, 32'sd0});
        vec_pending.push_back('{32'sd0, 32'sd1, S_MAX});
        vec_pending.push_back('{32'sd0, 32'sd1, S_MIN});
        vec_pending.push_back('{32'sd3, 32'sd4, 32'sd0});
        vec_pending.push_back('{-32'sd3, -32'sd4, 32'sd12});
        vec_pending.push_back('{32'sd123456, -32'sd654321, -32'sd98765});
        vec_pending.push_back('{-32'sd1, S_MAX, -32'sd1});

        for (k = 0; k < NUM_RANDOM; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: v = '{$urandom, $urandom, $urandom};
                5, 6, 7:
                begin
                    v.east  = $urandom;
                    v.north = $urandom;
                    v.up    = $urandom;
                    v.east  = v.east >>> $urandom_range(11, 31);
                    v.north = v.north >>> $urandom_range(11, 31);
                    v.up    = v.up >>> $urandom_range(11, 31);
                end
                8: v = '{rand_comp(), 32'sd0, rand_comp()};
                default: v = '{rand_comp(), rand_comp(), rand_comp()};
            endcase
            vec_pending.push_back(v);
        end

        while (vec_pending.size() != 0 || polar_expected.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #1ms;
        $display("FAILURE");
        $finish;
    end

endmodule
